FILE: rtl/hsvpwm_pkg.sv
package hsvpwm_pkg;

  localparam int unsigned HUE_W    = 12;
  localparam int unsigned LVL_W    = 8;
  localparam int unsigned FRAC_W   = 10;
  localparam int unsigned REM_W    = 10;

  // Width of the PWM timer compare field; duties saturate at its full count.
  localparam int unsigned DUTY_BITS = 8;
  localparam logic [LVL_W-1:0] DUTY_LIMIT =
    (DUTY_BITS >= LVL_W) ? {LVL_W{1'b1}} : LVL_W'((1 << DUTY_BITS) - 1);

  localparam int unsigned PEAK_DUTY_RESET = 127;

  // Hue span of one sector, in tenths of a degree.
  localparam int unsigned HUE_SECTOR = 600;

  // The fraction is rem * 1024 / 600 = (rem * 128) / 75. The quotient by 75 is
  // estimated with floor(2^20 / 75) and then corrected by at most one.
  localparam int unsigned FRAC_X_W    = REM_W + 7;
  localparam int unsigned RECIP_75    = (1 << 20) / 75;
  localparam int unsigned RECIP_W     = 14;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned PROD_W      = FRAC_X_W + RECIP_W;
  localparam int unsigned DIV_FRAC    = 75;

  // 255 * 1024, the unit of the s * f products.
  localparam int unsigned FULL_SCALE = 261120;
  localparam int unsigned SF_W       = 18;
  localparam int unsigned QY_W       = 26;

  typedef enum logic [2:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYAN = 3'd2,
    SECT_CYAN_BLU = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t           sector;
    logic [FRAC_W-1:0] frac;
    logic [LVL_W-1:0]  sat;
    logic [LVL_W-1:0]  bri;
    logic [LVL_W-1:0]  p;
  } frac_t;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } level_t;

  typedef struct packed {
    level_t           level;
    logic [LVL_W-1:0] red_duty;
    logic [LVL_W-1:0] green_duty;
    logic [LVL_W-1:0] blue_duty;
  } result_t;

  // floor(x / 255) for x up to 255 * 255, without a divider.
  function automatic logic [LVL_W-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'(x >> 8) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

FILE: rtl/hsvpwm_if.sv
interface hsvpwm_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] hue_tenths;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue_tenths, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue_tenths, input saturation, input brightness,
                  output ready);
endinterface

interface hsvpwm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic [7:0] red_duty;
  logic [7:0] green_duty;
  logic [7:0] blue_duty;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  output red_duty, output green_duty, output blue_duty, input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  input red_duty, input green_duty, input blue_duty, output ready);
endinterface

FILE: rtl/hsvpwm_frac.sv
module hsvpwm_frac (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsvpwm_pkg::HUE_W-1:0] hue,
  input  logic [hsvpwm_pkg::LVL_W-1:0] sat,
  input  logic [hsvpwm_pkg::LVL_W-1:0] bri,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hsvpwm_pkg::frac_t           out_data
);
  import hsvpwm_pkg::*;

  logic en1, en2, en3;
  logic s1_valid, s2_valid, s3_valid;

  logic [2:0]       sect_raw;
  logic [HUE_W-1:0] sect_base;
  logic [HUE_W-1:0] rem_full;
  sector_t          sect_c;

  sector_t          s1_sector;
  logic [REM_W-1:0] s1_rem;
  logic [LVL_W-1:0] s1_sat, s1_bri;

  sector_t             s2_sector;
  logic [FRAC_X_W-1:0] s2_x;
  logic [PROD_W-1:0]   s2_prod;
  logic [15:0]         s2_pv;
  logic [LVL_W-1:0]    s2_sat, s2_bri;

  logic [FRAC_W-1:0]   q0;
  logic [FRAC_X_W-1:0] rem75;
  frac_t               s3;

  assign en3 = !s3_valid || out_ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign in_ready  = en1;
  assign out_valid = s3_valid;
  assign out_data  = s3;

  // Sector by comparing against the sector boundaries; hues past the last
  // boundary fall into a seventh span that folds back onto the first sector.
  always_comb begin
    priority if (hue >= HUE_W'(6 * HUE_SECTOR)) begin
      sect_raw = 3'd6; sect_base = HUE_W'(6 * HUE_SECTOR);
    end else if (hue >= HUE_W'(5 * HUE_SECTOR)) begin
      sect_raw = 3'd5; sect_base = HUE_W'(5 * HUE_SECTOR);
    end else if (hue >= HUE_W'(4 * HUE_SECTOR)) begin
      sect_raw = 3'd4; sect_base = HUE_W'(4 * HUE_SECTOR);
    end else if (hue >= HUE_W'(3 * HUE_SECTOR)) begin
      sect_raw = 3'd3; sect_base = HUE_W'(3 * HUE_SECTOR);
    end else if (hue >= HUE_W'(2 * HUE_SECTOR)) begin
      sect_raw = 3'd2; sect_base = HUE_W'(2 * HUE_SECTOR);
    end else if (hue >= HUE_W'(HUE_SECTOR)) begin
      sect_raw = 3'd1; sect_base = HUE_W'(HUE_SECTOR);
    end else begin
      sect_raw = 3'd0; sect_base = '0;
    end
    rem_full = hue - sect_base;
    sect_c   = (sect_raw == 3'd6) ? SECT_RED_YEL : sector_t'(sect_raw);
  end

  always_comb begin
    q0    = s2_prod[RECIP_SHIFT +: FRAC_W];
    rem75 = s2_x - FRAC_X_W'(q0 * DIV_FRAC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sector <= sect_c;
      s1_rem    <= rem_full[REM_W-1:0];
      s1_sat    <= sat;
      s1_bri    <= bri;
    end
    if (en2) begin
      s2_sector <= s1_sector;
      s2_x      <= {s1_rem, 7'b0};
      s2_prod   <= PROD_W'({s1_rem, 7'b0}) * PROD_W'(RECIP_75);
      s2_pv     <= s1_bri * (8'd255 - s1_sat);
      s2_sat    <= s1_sat;
      s2_bri    <= s1_bri;
    end
    if (en3) begin
      s3.sector <= s2_sector;
      s3.frac   <= q0 + FRAC_W'(rem75 >= FRAC_X_W'(DIV_FRAC));
      s3.sat    <= s2_sat;
      s3.bri    <= s2_bri;
      s3.p      <= div255(s2_pv);
    end
  end

endmodule

FILE: rtl/hsvpwm_level.sv
module hsvpwm_level (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsvpwm_pkg::frac_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsvpwm_pkg::level_t out_data
);
  import hsvpwm_pkg::*;

  logic en4, en5, en6;
  logic s4_valid, s5_valid, s6_valid;

  sector_t          s4_sector, s5_sector;
  logic [SF_W-1:0]  s4_sf, s4_sg;
  logic [LVL_W-1:0] s4_bri, s4_p, s5_bri, s5_p;
  logic [QY_W-1:0]  s5_qy, s5_ty;

  logic [LVL_W-1:0] q, t;
  level_t           sel;
  level_t           s6;

  assign en6 = !s6_valid || out_ready;
  assign en5 = !s5_valid || en6;
  assign en4 = !s4_valid || en5;
  assign in_ready  = en4;
  assign out_valid = s6_valid;
  assign out_data  = s6;

  // Both products never exceed 255 * 1024, so the differences never go negative.
  always_comb begin
    q = div255(s5_qy[QY_W-1:10]);
    t = div255(s5_ty[QY_W-1:10]);
    unique case (s5_sector)
      SECT_RED_YEL:  sel = '{red: s5_bri, green: t,      blue: s5_p};
      SECT_YEL_GRN:  sel = '{red: q,      green: s5_bri, blue: s5_p};
      SECT_GRN_CYAN: sel = '{red: s5_p,   green: s5_bri, blue: t};
      SECT_CYAN_BLU: sel = '{red: s5_p,   green: q,      blue: s5_bri};
      SECT_BLU_MAG:  sel = '{red: t,      green: s5_p,   blue: s5_bri};
      default:       sel = '{red: s5_bri, green: s5_p,   blue: q};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (en4) s4_valid <= in_valid;
      if (en5) s5_valid <= s4_valid;
      if (en6) s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_sector <= in_data.sector;
      s4_sf     <= SF_W'(in_data.sat * in_data.frac);
      s4_sg     <= SF_W'(in_data.sat * (11'd1024 - {1'b0, in_data.frac}));
      s4_bri    <= in_data.bri;
      s4_p      <= in_data.p;
    end
    if (en5) begin
      s5_sector <= s4_sector;
      s5_qy     <= QY_W'(s4_bri * (SF_W'(FULL_SCALE) - s4_sf));
      s5_ty     <= QY_W'(s4_bri * (SF_W'(FULL_SCALE) - s4_sg));
      s5_bri    <= s4_bri;
      s5_p      <= s4_p;
    end
    if (en6) begin
      s6 <= sel;
    end
  end

endmodule

FILE: rtl/hsvpwm_duty.sv
module hsvpwm_duty (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hsvpwm_pkg::LVL_W-1:0] peak_duty,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hsvpwm_pkg::level_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hsvpwm_pkg::result_t          out_data
);
  import hsvpwm_pkg::*;

  logic en7, en8;
  logic s7_valid, s8_valid;

  level_t      s7_level;
  logic [15:0] s7_mr, s7_mg, s7_mb;
  result_t     s8;

  assign en8 = !s8_valid || out_ready;
  assign en7 = !s7_valid || en8;
  assign in_ready  = en7;
  assign out_valid = s8_valid;
  assign out_data  = s8;

  function automatic logic [LVL_W-1:0] clip(input logic [LVL_W-1:0] d);
    return (d > DUTY_LIMIT) ? DUTY_LIMIT : d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else begin
      if (en7) s7_valid <= in_valid;
      if (en8) s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_level <= in_data;
      s7_mr    <= in_data.red   * peak_duty;
      s7_mg    <= in_data.green * peak_duty;
      s7_mb    <= in_data.blue  * peak_duty;
    end
    if (en8) begin
      s8.level      <= s7_level;
      s8.red_duty   <= clip(div255(s7_mr));
      s8.green_duty <= clip(div255(s7_mg));
      s8.blue_duty  <= clip(div255(s7_mb));
    end
  end

endmodule

FILE: rtl/hsv_to_rgb_pwm_duty.sv
// Channel   Direction  Carries
// color     sink       hue_tenths[11:0], saturation[7:0], brightness[7:0]
// result    source     red/green/blue_level[7:0], red/green/blue_duty[7:0]
// cfg       write      cfg_we, cfg_wdata[7:0] -> peak_duty
//
// One item is accepted per clock while no stall holds color.ready low. An item
// passes eight register stages, the first loaded by the accepting edge.
// Reset (rst, synchronous) empties every stage and loads peak_duty with 127.
// Each stage holds its item while the next one is full and stalled, so a stall
// on result fills empty stages first and then backs up to color.ready.
module hsv_to_rgb_pwm_duty (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hsvpwm_pkg::LVL_W-1:0] cfg_wdata,
  hsvpwm_in_if.sink                    color,
  hsvpwm_out_if.source                 result
);
  import hsvpwm_pkg::*;

  // Largest duty for a full-scale channel. The user must write it only while the
  // pipeline is empty (not enforced), so every item in flight sees one value.
  logic [LVL_W-1:0] peak_duty;

  logic    frac_valid, frac_ready;
  frac_t   frac_data;
  logic    lvl_valid, lvl_ready;
  level_t  lvl_data;
  result_t res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_duty <= LVL_W'(PEAK_DUTY_RESET);
    end else if (cfg_we) begin
      peak_duty <= cfg_wdata;
    end
  end

  // Stages one to three: sector, remainder and the 10-bit hue fraction, plus
  // the p level, which needs only saturation and value.
  hsvpwm_frac u_frac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (color.valid),
    .in_ready  (color.ready),
    .hue       (color.hue_tenths),
    .sat       (color.saturation),
    .bri       (color.brightness),
    .out_valid (frac_valid),
    .out_ready (frac_ready),
    .out_data  (frac_data)
  );

  // Stages four to six: the q and t levels and the per-sector arrangement.
  hsvpwm_level u_level (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frac_valid),
    .in_ready  (frac_ready),
    .in_data   (frac_data),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_data  (lvl_data)
  );

  // Stages seven and eight: scaling each level to a PWM duty. The last stage
  // is the output register.
  hsvpwm_duty u_duty (
    .clk       (clk),
    .rst       (rst),
    .peak_duty (peak_duty),
    .in_valid  (lvl_valid),
    .in_ready  (lvl_ready),
    .in_data   (lvl_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (res_data)
  );

  assign result.red_level   = res_data.level.red;
  assign result.green_level = res_data.level.green;
  assign result.blue_level  = res_data.level.blue;
  assign result.red_duty    = res_data.red_duty;
  assign result.green_duty  = res_data.green_duty;
  assign result.blue_duty   = res_data.blue_duty;

endmodule
